FILE: rtl/nir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_pkg: shared types and constants of the NEC IR frame decoder
// Status codes, step numbers, register indexes and reset values, and the
// classified item that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package nir_pkg;

    localparam int WIN_W   = 32;
    localparam int IVL_W   = 16;
    localparam int STEP_W  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH  = 2;

    localparam logic [2:0] ST_IDLE         = 3'd0;
    localparam logic [2:0] ST_TIMING_ERR   = 3'd1;
    localparam logic [2:0] ST_CHECKSUM_ERR = 3'd2;
    localparam logic [2:0] ST_PACKET       = 3'd3;
    localparam logic [2:0] ST_REPEAT       = 3'd4;

    localparam logic [STEP_W-1:0] STEP_START     = 6'd2;
    localparam logic [STEP_W-1:0] STEP_FIRST_BIT = 6'd3;
    localparam logic [STEP_W-1:0] STEP_LAST_BIT  = 6'd34;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 6'd35;
    localparam logic [STEP_W-1:0] STEP_REPEAT1   = 6'd36;
    localparam logic [STEP_W-1:0] STEP_REPEAT2   = 6'd37;

    localparam logic [2:0] OVF_LIMIT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_WIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT1_WIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT2_WIN = 3'd4;

    localparam logic [WIN_W-1:0] RST_START_WIN   = 32'd1900569000;
    localparam logic [WIN_W-1:0] RST_ONE_WIN     = 32'd327684000;
    localparam logic [WIN_W-1:0] RST_ZERO_WIN    = 32'd170395500;
    localparam logic [WIN_W-1:0] RST_REPEAT1_WIN = 32'd1572885000;
    localparam logic [WIN_W-1:0] RST_REPEAT2_WIN = 32'd0;

    typedef struct packed {
        logic mode;
        logic in_start;
        logic in_one;
        logic in_zero;
        logic in_repeat1;
        logic in_repeat2;
    } nir_class_t;

    typedef struct packed {
        logic full;
        logic empty;
    } nir_qstat_t;

endpackage

FILE: rtl/nir_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_if: channel interfaces of the NEC IR frame decoder
// Item channel (edge or overflow tick) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface nir_item_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] interval;

    modport source (output valid, output mode, output interval, input ready);
    modport sink   (input valid, input mode, input interval, output ready);
endinterface

interface nir_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] address_low;
    logic [7:0] address_high;
    logic [7:0] command;
    logic       new_packet;

    modport source (output valid, output status, output address_low,
                    output address_high, output command, output new_packet,
                    input ready);
    modport sink   (input valid, input status, input address_low,
                    input address_high, input command, input new_packet,
                    output ready);
endinterface

FILE: rtl/nir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_front: item intake and interval classification
// Holds the window registers and tests each interval against every window.
// ----------------------------------------------------------------------------
module nir_front
    import nir_pkg::*;
#(
    parameter int TIME_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_wr_data,
    nir_item_if.sink             item,
    input  nir_qstat_t           qstat,
    output logic                 push,
    output nir_class_t           push_data
);

    localparam int USED_W = (TIME_WIDTH < IVL_W) ? TIME_WIDTH : IVL_W;
    localparam logic [IVL_W-1:0] T_MASK = IVL_W'((33'd1 << USED_W) - 33'd1);

    logic [WIN_W-1:0] start_win_reg;
    logic [WIN_W-1:0] one_win_reg;
    logic [WIN_W-1:0] zero_win_reg;
    logic [WIN_W-1:0] rep1_win_reg;
    logic [WIN_W-1:0] rep2_win_reg;
    logic [IVL_W-1:0] t;

    function automatic logic in_win(input logic [WIN_W-1:0] win,
                                    input logic [IVL_W-1:0] tv);
        in_win = (tv >= win[15:0]) && (tv <= win[31:16]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_win_reg <= RST_START_WIN;
            one_win_reg   <= RST_ONE_WIN;
            zero_win_reg  <= RST_ZERO_WIN;
            rep1_win_reg  <= RST_REPEAT1_WIN;
            rep2_win_reg  <= RST_REPEAT2_WIN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_START_WIN:   start_win_reg <= cfg_wr_data;
                CFG_ONE_WIN:     one_win_reg   <= cfg_wr_data;
                CFG_ZERO_WIN:    zero_win_reg  <= cfg_wr_data;
                CFG_REPEAT1_WIN: rep1_win_reg  <= cfg_wr_data;
                CFG_REPEAT2_WIN: rep2_win_reg  <= cfg_wr_data;
                default:         ;
            endcase
        end
    end

    assign t          = item.interval & T_MASK;
    assign item.ready = !qstat.full;
    assign push       = item.valid && !qstat.full;

    always_comb
    begin
        push_data.mode       = item.mode;
        push_data.in_start   = in_win(start_win_reg, t);
        push_data.in_one     = in_win(one_win_reg, t);
        push_data.in_zero    = in_win(zero_win_reg, t);
        push_data.in_repeat1 = in_win(rep1_win_reg, t);
        push_data.in_repeat2 = in_win(rep2_win_reg, t);
    end

endmodule

FILE: rtl/nir_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_queue: two-entry queue between front end and back end
// Carries classified items; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module nir_queue
    import nir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  nir_class_t push_data,
    input  logic       pop,
    output nir_class_t head,
    output nir_qstat_t qstat,
    output logic [$clog2(QDEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    nir_class_t       mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign head        = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign level       = count_reg;

endmodule

FILE: rtl/nir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_back: frame sequencer and result register
// Advances the edge step, stores data bits, checks the checksum, tracks
// repeat codes and overflow ticks, and holds the result for transfer.
// ----------------------------------------------------------------------------
module nir_back
    import nir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  nir_class_t head,
    input  nir_qstat_t qstat,
    output logic       pop,
    nir_result_if.source result
);

    logic [STEP_W-1:0] step_reg,   step_next;
    logic [7:0]        addr_low_reg,  addr_low_next;
    logic [7:0]        addr_high_reg, addr_high_next;
    logic [7:0]        command_reg,   command_next;
    logic [7:0]        cmd_inv_reg,   cmd_inv_next;
    logic [2:0]        status_reg,    status_next;
    logic [2:0]        ovf_reg,       ovf_next;
    logic              newp_next;
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [7:0]        out_addr_low_reg;
    logic [7:0]        out_addr_high_reg;
    logic [7:0]        out_command_reg;
    logic              out_newp_reg;
    logic [STEP_W-1:0] s;
    logic [4:0]        bit_idx;
    logic [31:0]       frame;

    assign pop = !qstat.empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        step_next      = step_reg;
        status_next    = status_reg;
        ovf_next       = ovf_reg;
        newp_next      = 1'b0;
        s              = step_reg + STEP_W'(1);
        bit_idx        = 5'(s - STEP_FIRST_BIT);
        frame          = {cmd_inv_reg, command_reg, addr_high_reg, addr_low_reg};

        if (head.mode)
        begin
            if (status_reg == ST_REPEAT)
                ovf_next = ovf_reg + 3'd1;
            if (ovf_next == OVF_LIMIT)
            begin
                step_next   = '0;
                status_next = ST_IDLE;
            end
        end
        else
        begin
            ovf_next  = '0;
            step_next = s;
            priority if (s == STEP_START)
            begin
                if (!head.in_start)
                begin
                    step_next   = '0;
                    status_next = ST_TIMING_ERR;
                end
            end
            else if (s >= STEP_FIRST_BIT && s <= STEP_LAST_BIT)
            begin
                if (head.in_one || head.in_zero)
                    frame[bit_idx] = head.in_one;
                else
                begin
                    step_next   = '0;
                    status_next = ST_TIMING_ERR;
                end
            end
            else if (s == STEP_CHECK)
            begin
                if (command_reg == ~cmd_inv_reg)
                begin
                    status_next = ST_PACKET;
                    newp_next   = 1'b1;
                end
                else
                begin
                    step_next   = '0;
                    status_next = ST_CHECKSUM_ERR;
                end
            end
            else if (s == STEP_REPEAT1)
            begin
                if (!head.in_repeat1)
                begin
                    if (head.in_start)
                        step_next = STEP_START;
                    else
                    begin
                        step_next   = '0;
                        status_next = ST_TIMING_ERR;
                    end
                end
            end
            else if (s == STEP_REPEAT2)
            begin
                if (head.in_repeat2)
                begin
                    step_next   = STEP_CHECK;
                    status_next = ST_REPEAT;
                end
                else if (head.in_start)
                    step_next = STEP_START;
                else
                begin
                    step_next   = '0;
                    status_next = ST_TIMING_ERR;
                end
            end
            else
            begin
                step_next = s;
            end
        end

        addr_low_next  = frame[7:0];
        addr_high_next = frame[15:8];
        command_next   = frame[23:16];
        cmd_inv_next   = frame[31:24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= '0;
            addr_low_reg      <= '0;
            addr_high_reg     <= '0;
            command_reg       <= '0;
            cmd_inv_reg       <= '0;
            status_reg        <= ST_IDLE;
            ovf_reg           <= '0;
            out_valid_reg     <= 1'b0;
            out_status_reg    <= ST_IDLE;
            out_addr_low_reg  <= '0;
            out_addr_high_reg <= '0;
            out_command_reg   <= '0;
            out_newp_reg      <= 1'b0;
        end
        else if (pop)
        begin
            step_reg          <= step_next;
            addr_low_reg      <= addr_low_next;
            addr_high_reg     <= addr_high_next;
            command_reg       <= command_next;
            cmd_inv_reg       <= cmd_inv_next;
            status_reg        <= status_next;
            ovf_reg           <= ovf_next;
            out_valid_reg     <= 1'b1;
            out_status_reg    <= status_next;
            out_addr_low_reg  <= addr_low_next;
            out_addr_high_reg <= addr_high_next;
            out_command_reg   <= command_next;
            out_newp_reg      <= newp_next;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.address_low  = out_addr_low_reg;
    assign result.address_high = out_addr_high_reg;
    assign result.command      = out_command_reg;
    assign result.new_packet   = out_newp_reg;

endmodule

FILE: rtl/nec_ir_frame_decoder_top.sv
`timescale 1ns / 1ps
// NEC IR frame decoder. Each item is a falling edge with its timer interval
// or a timer overflow tick, and each gives exactly one result. One item is
// taken every clock cycle while the queue is not full, which depends on the
// result channel. Each item is stored in the two-entry queue after the
// window compares, then the frame sequencer registers its result. The user
// is to write window registers through the plain write port while idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top: NEC IR frame decoder top level
// Front end classifies intervals, queue decouples, back end sequences frames.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top
    import nir_pkg::*;
#(
    parameter int TIME_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_wr_data,
    nir_item_if.sink             item,
    nir_result_if.source         result
);

    nir_class_t push_data;
    nir_class_t head;
    nir_qstat_t qstat;
    logic       push;
    logic       pop;
    logic [$clog2(QDEPTH+1)-1:0] level;

    nir_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .qstat       (qstat),
        .push        (push),
        .push_data   (push_data)
    );

    nir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat),
        .level     (level)
    );

    nir_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

    a_packet_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.new_packet |-> result.status == ST_PACKET)
        else $error("packet pulse without packet status");

    a_item_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> (level != '0) || result.valid)
        else $error("transferred item neither queued nor presented");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level != '0)
        else $error("back end took an item from an empty queue");

endmodule

FILE: test/nec_ir_frame_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top_tb: self-checking bench for the NEC IR decoder
// Drives edges and overflow ticks through the item channel in random bursts.
// Stalls the result channel, including one long hold-off. Every result is
// compared against a cycle-free decoder model kept in a scoreboard class.
// Window settings change between phases, extremes and overlaps among them.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top_tb;
    import nir_pkg::*;

    localparam logic MODE_EDGE      = 1'b0;
    localparam logic MODE_TICK      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   PHASE_ITEMS    = 275;
    localparam int   HOLD_AFTER     = 700;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   REPORT_CAP     = 40;

    typedef struct {
        logic [2:0] status;
        logic [7:0] address_low;
        logic [7:0] address_high;
        logic [7:0] command;
        logic       new_packet;
    } frame_out_t;

    class nec_frame_scoreboard;
        logic [31:0] windows [0:4];
        logic [5:0]  edge_step;
        logic [31:0] frame_bits;
        logic [2:0]  status;
        logic [2:0]  tick_count;
        frame_out_t  expected_q [$];
        int          mismatches;
        int          checked;
        int          packets;
        int          repeats;
        int          timeouts;
        int          timing_errors;
        int          checksum_errors;

        function new();
            windows[CFG_START_WIN]   = RST_START_WIN;
            windows[CFG_ONE_WIN]     = RST_ONE_WIN;
            windows[CFG_ZERO_WIN]    = RST_ZERO_WIN;
            windows[CFG_REPEAT1_WIN] = RST_REPEAT1_WIN;
            windows[CFG_REPEAT2_WIN] = RST_REPEAT2_WIN;
            edge_step       = '0;
            frame_bits      = '0;
            status          = ST_IDLE;
            tick_count      = '0;
            mismatches      = 0;
            checked         = 0;
            packets         = 0;
            repeats         = 0;
            timeouts        = 0;
            timing_errors   = 0;
            checksum_errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit in_window(logic [CFG_IDX_W-1:0] idx, logic [15:0] t);
            return (t >= windows[idx][15:0]) && (t <= windows[idx][31:16]);
        endfunction

        function void abort_frame(logic [2:0] code);
            edge_step = '0;
            status    = code;
            if (code == ST_TIMING_ERR)
                timing_errors++;
            else
                checksum_errors++;
        endfunction

        function void note_item(logic m, logic [15:0] t);
            frame_out_t want;
            logic [5:0] bit_pos;
            logic       fresh;
            fresh = 1'b0;
            if (m == MODE_TICK)
            begin
                if (status == ST_REPEAT)
                    tick_count = tick_count + 3'd1;
                if (tick_count == OVF_LIMIT)
                begin
                    if (status == ST_REPEAT)
                        timeouts++;
                    edge_step = '0;
                    status    = ST_IDLE;
                end
            end
            else
            begin
                tick_count = '0;
                edge_step  = edge_step + 6'd1;
                if (edge_step == STEP_START)
                begin
                    if (!in_window(CFG_START_WIN, t))
                        abort_frame(ST_TIMING_ERR);
                end
                else if (edge_step >= STEP_FIRST_BIT && edge_step <= STEP_LAST_BIT)
                begin
                    bit_pos = edge_step - STEP_FIRST_BIT;
                    if (in_window(CFG_ONE_WIN, t))
                        frame_bits[bit_pos] = 1'b1;
                    else if (in_window(CFG_ZERO_WIN, t))
                        frame_bits[bit_pos] = 1'b0;
                    else
                        abort_frame(ST_TIMING_ERR);
                end
                else if (edge_step == STEP_CHECK)
                begin
                    if (frame_bits[23:16] == ~frame_bits[31:24])
                    begin
                        status = ST_PACKET;
                        fresh  = 1'b1;
                        packets++;
                    end
                    else
                        abort_frame(ST_CHECKSUM_ERR);
                end
                else if (edge_step == STEP_REPEAT1)
                begin
                    if (!in_window(CFG_REPEAT1_WIN, t))
                    begin
                        if (in_window(CFG_START_WIN, t))
                            edge_step = STEP_START;
                        else
                            abort_frame(ST_TIMING_ERR);
                    end
                end
                else if (edge_step == STEP_REPEAT2)
                begin
                    if (in_window(CFG_REPEAT2_WIN, t))
                    begin
                        edge_step = STEP_CHECK;
                        status    = ST_REPEAT;
                        repeats++;
                    end
                    else if (in_window(CFG_START_WIN, t))
                        edge_step = STEP_START;
                    else
                        abort_frame(ST_TIMING_ERR);
                end
            end
            want.status       = status;
            want.address_low  = frame_bits[7:0];
            want.address_high = frame_bits[15:8];
            want.command      = frame_bits[23:16];
            want.new_packet   = fresh;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t ns mismatch: %s", $time, what);
        endtask

        task check_result(frame_out_t got);
            frame_out_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending, status %0d", got.status));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.address_low !== want.address_low)
                report_mismatch($sformatf("address_low %h, want %h",
                                          got.address_low, want.address_low));
            if (got.address_high !== want.address_high)
                report_mismatch($sformatf("address_high %h, want %h",
                                          got.address_high, want.address_high));
            if (got.command !== want.command)
                report_mismatch($sformatf("command %h, want %h", got.command, want.command));
            if (got.new_packet !== want.new_packet)
                report_mismatch($sformatf("new_packet %b, want %b",
                                          got.new_packet, want.new_packet));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIN_W-1:0]     cfg_wr_data;

    nir_item_if   item_ch ();
    nir_result_if result_ch ();

    nec_ir_frame_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    nec_frame_scoreboard board;
    int          burst_left    = 0;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;
    int          style_left    = 0;
    int          ready_style   = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    logic [7:0]  ready_pattern = 8'hFF;
    logic [31:0] ready_roll;
    frame_out_t  seen;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen.status       = result_ch.status;
                seen.address_low  = result_ch.address_low;
                seen.address_high = result_ch.address_high;
                seen.command      = result_ch.command;
                seen.new_packet   = result_ch.new_packet;
                board.check_result(seen);
            end
            if (!hold_done && board.checked >= HOLD_AFTER && burst_left > 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
        end
        ready_roll = $urandom;
        if (style_left == 0)
        begin
            ready_style   = $urandom_range(0, 3);
            style_left    = $urandom_range(40, 300);
            ready_pattern = ready_roll[15:8] | 8'h01;
        end
        else
            style_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (ready_style)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ready_roll[0];
                2:       result_ch.ready <= (ready_roll[3:0] != 4'd0);
                default: result_ch.ready <= ready_pattern[style_left % 8];
            endcase
        end
    end

    function automatic logic [15:0] any_interval();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    function automatic logic [15:0] pick_inside(logic [31:0] w);
        logic [31:0] r;
        if (w[15:0] > w[31:16])
            r = $urandom;
        else if ($urandom_range(0, 5) == 0)
            r = {16'd0, w[15:0]};
        else if ($urandom_range(0, 4) == 0)
            r = {16'd0, w[31:16]};
        else
            r = $urandom_range(w[31:16], w[15:0]);
        return r[15:0];
    endfunction

    function automatic logic [15:0] pick_outside(logic [31:0] w);
        logic [31:0] r;
        if (w[15:0] > w[31:16] || (w[15:0] == 16'h0000 && w[31:16] == 16'hFFFF))
            r = $urandom;
        else if (w[15:0] != 16'h0000 && (w[31:16] == 16'hFFFF || $urandom_range(0, 1) == 1))
            r = $urandom_range(w[15:0] - 1, 0);
        else
            r = $urandom_range(16'hFFFF, w[31:16] + 1);
        return r[15:0];
    endfunction

    function automatic logic [31:0] random_window();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom_range(0, 60000);
        hi = lo + $urandom_range(0, 5000);
        if ($urandom_range(0, 5) == 0)
            return {lo[15:0], hi[15:0]};
        return {hi[15:0], lo[15:0]};
    endfunction

    task automatic send_item(input logic m, input logic [15:0] t);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        item_ch.valid    <= 1'b1;
        item_ch.mode     <= m;
        item_ch.interval <= t;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        board.note_item(m, t);
        items_sent++;
        burst_left--;
        if (burst_left == 0)
            item_ch.valid <= 1'b0;
    endtask

    task automatic settle_decoder();
        if (burst_left != 0)
        begin
            item_ch.valid <= 1'b0;
            burst_left = 0;
        end
        while (board.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        board.windows[idx] = value;
        @(posedge clk);
    endtask

    task automatic apply_windows(input logic [31:0] start_w, input logic [31:0] one_w,
                                 input logic [31:0] zero_w, input logic [31:0] rep1_w,
                                 input logic [31:0] rep2_w);
        settle_decoder();
        write_reg(CFG_START_WIN, start_w);
        write_reg(CFG_ONE_WIN, one_w);
        write_reg(CFG_ZERO_WIN, zero_w);
        write_reg(CFG_REPEAT1_WIN, rep1_w);
        write_reg(CFG_REPEAT2_WIN, rep2_w);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame();
        logic [31:0] payload;
        logic [31:0] r;
        logic [15:0] t;
        int          guard;
        guard = 0;
        // drop out of any half-received frame first
        while (board.edge_step != 6'd0 && board.edge_step != STEP_CHECK && guard < 48)
        begin
            send_item(MODE_EDGE, any_interval());
            guard++;
        end
        if (board.edge_step == 6'd0)
            send_item(MODE_EDGE, any_interval());
        if ($urandom_range(0, 15) == 0)
            send_item(MODE_EDGE, pick_outside(board.windows[CFG_START_WIN]));
        else
            send_item(MODE_EDGE, pick_inside(board.windows[CFG_START_WIN]));
        payload = $urandom;
        r = $urandom;
        payload[31:24] = ($urandom_range(0, 7) == 0) ? r[7:0] : ~payload[23:16];
        for (int i = 0; i < 32; i++)
        begin
            if ($urandom_range(0, 127) == 0)
                t = any_interval();
            else if (payload[i])
                t = pick_inside(board.windows[CFG_ONE_WIN]);
            else
                t = pick_inside(board.windows[CFG_ZERO_WIN]);
            send_item(MODE_EDGE, t);
        end
        if ($urandom_range(0, 5) == 0)
            send_item(MODE_TICK, any_interval());
        send_item(MODE_EDGE, any_interval());
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 15))
                0:       t = pick_inside(board.windows[CFG_START_WIN]);
                1:       t = any_interval();
                default: t = pick_inside(board.windows[CFG_REPEAT1_WIN]);
            endcase
            send_item(MODE_EDGE, t);
            case ($urandom_range(0, 15))
                0:       t = pick_inside(board.windows[CFG_START_WIN]);
                1:       t = any_interval();
                default: t = pick_inside(board.windows[CFG_REPEAT2_WIN]);
            endcase
            send_item(MODE_EDGE, t);
            repeat ($urandom_range(0, 3)) send_item(MODE_TICK, any_interval());
        end
        repeat ($urandom_range(0, 6)) send_item(MODE_TICK, any_interval());
    endtask

    task automatic random_traffic(input int count);
        logic [31:0] r;
        int          first;
        first = items_sent;
        while (items_sent - first < count)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    r = $urandom;
                    send_item(r[16], r[15:0]);
                end
            end
            else
                send_frame();
        end
    endtask

    initial
    begin
        board = new();
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_START_WIN;
        cfg_wr_data      = '0;
        item_ch.valid    = 1'b0;
        item_ch.mode     = MODE_EDGE;
        item_ch.interval = '0;
        result_ch.ready  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_TICK, 16'hFFFF);
        send_item(MODE_EDGE, 16'h0000);
        send_item(MODE_EDGE, 16'hFFFF);
        send_item(MODE_EDGE, 16'hFFFF);
        send_item(MODE_EDGE, 16'd25000);
        send_item(MODE_EDGE, 16'd5000);
        send_item(MODE_EDGE, 16'd1900);
        send_item(MODE_EDGE, 16'd3000);
        send_item(MODE_TICK, 16'h0000);
        send_item(MODE_EDGE, 16'h0000);
        send_item(MODE_EDGE, 16'd29000);
        send_item(MODE_EDGE, 16'd4000);
        send_item(MODE_EDGE, 16'd2600);
        send_item(MODE_EDGE, 16'd24999);
        random_traffic(PHASE_ITEMS);

        apply_windows({16'd29000, 16'd25000}, {16'd5000, 16'd4000}, {16'd2600, 16'd1900},
                      {16'd24000, 16'd21000}, {16'd12000, 16'd10000});
        random_traffic(PHASE_ITEMS);

        // overlapping windows: one beats zero, first repeat beats start
        apply_windows({16'd300, 16'd100}, {16'd3000, 16'd1000}, {16'd4000, 16'd2000},
                      {16'd400, 16'd250}, {16'd5000, 16'd5000});
        random_traffic(PHASE_ITEMS);

        apply_windows(32'hFFFF_FFFF, 32'h0000_0000, {16'hFFFF, 16'h0001},
                      {16'h0000, 16'hFFFF}, {16'hFFFF, 16'h0000});
        random_traffic(PHASE_ITEMS);

        apply_windows({16'hFFFF, 16'h0000}, {16'd10, 16'd20}, {16'hFFFF, 16'h0000},
                      {16'hFFFF, 16'h0000}, {16'd7, 16'd9});
        random_traffic(PHASE_ITEMS);

        repeat (2)
        begin
            apply_windows(random_window(), random_window(), random_window(),
                          random_window(), random_window());
            random_traffic(PHASE_ITEMS);
        end

        settle_decoder();
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
        $display("covered %0d items: %0d frames decoded, %0d repeat codes, %0d repeat time-outs",
                 items_sent, board.packets, board.repeats, board.timeouts);
        $display("timing errors %0d, checksum errors %0d, results checked %0d, mismatches %0d",
                 board.timing_errors, board.checksum_errors, board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
